>>> rtl/cyclic_interference_detector_macros.svh
// Assertion helpers for the RTL.
// Every check is clocked on clk and switched off while rst is high.
`ifndef CYCLIC_INTERFERENCE_DETECTOR_MACROS_SVH
`define CYCLIC_INTERFERENCE_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CID_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cid_pkg.sv
package cid_pkg;

  localparam int DOMAIN_W    = 8;
  localparam int COUNT_W     = 8;
  localparam int HIST_W      = 16;
  localparam int THRESH_W    = 9;
  localparam int WINDOW_W    = 16;
  localparam int BUCKET_ID_W = 3;
  localparam int OUT_HIST    = 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_FIELDS_W  = 3 * DOMAIN_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + BUCKET_ID_W + 1 + OUT_HIST * HIST_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ALERT_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_LENGTH = 1'b1;

  localparam logic [THRESH_W-1:0] ALERT_THRESHOLD_RESET = 9'd3;
  localparam logic [WINDOW_W-1:0] INTERVAL_LENGTH_RESET = 16'd10;

  localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};

  // Input word, last declared field in the lowest bits.
  typedef struct packed {
    logic [DOMAIN_W-1:0] holder_dom;
    logic [DOMAIN_W-1:0] req_dom;
    logic [DOMAIN_W-1:0] prior_dom;
  } in_word_t;

  // Result word, last declared field in the lowest bits, zero padding on top.
  typedef struct packed {
    logic [OUT_PAD_W-1:0]             pad;
    logic [OUT_HIST-1:0][HIST_W-1:0]  history;
    logic                             event_counted;
    logic [BUCKET_ID_W-1:0]           alert_bucket;
    logic                             alert;
  } out_word_t;

endpackage

>>> rtl/cyclic_interference_detector.sv
// A word accepted on s passes the input register, then the result register, before
// it is offered on m. Throughput: one word per cycle unless m_tready stalls the
// output; the counter and history update is a single pass.
// Reset (rst, synchronous): counters, histories and window count clear, alert
// threshold returns to 3, interval length to 10, both stream sides go idle.
`include "cyclic_interference_detector_macros.svh"

module cyclic_interference_detector #(
  parameter int BUCKET_CNT    = 4,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // prior domain [7:0], requesting domain [15:8], holding domain [23:16]
  input  logic [cid_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // alert [0], alert_bucket [3:1], event_counted [4], history_0 [20:5],
  // history_1..history_7 in 16-bit steps up to [132:117], zero pad [135:133]
  output logic [cid_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [cid_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cid_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int BW = (BUCKET_CNT > 1) ? $clog2(BUCKET_CNT) : 1;

  logic [cid_pkg::THRESH_W-1:0] alert_threshold;
  logic [cid_pkg::WINDOW_W-1:0] interval_length;

  logic [cid_pkg::COUNT_W-1:0] counters [BUCKET_CNT];
  logic [cid_pkg::HIST_W-1:0]  hist [BUCKET_CNT][HISTORY_DEPTH];
  logic [cid_pkg::WINDOW_W-1:0] window_count;

  logic              st_valid;
  cid_pkg::in_word_t st_word;
  cid_pkg::out_word_t out_word;

  logic advance;
  logic fire;
  logic event_hit;
  logic alert_hit;
  logic win_clear;
  logic [BW-1:0] idx;
  logic [cid_pkg::COUNT_W-1:0] cnt_inc;
  logic [cid_pkg::COUNT_W-1:0] cnt_next;
  logic [cid_pkg::HIST_W-1:0]  newest;
  logic [cid_pkg::HIST_W-1:0]  appended;
  logic [cid_pkg::WINDOW_W:0]  window_inc;
  logic [cid_pkg::OUT_HIST-1:0][cid_pkg::HIST_W-1:0] sel_hist;
  cid_pkg::out_word_t out_word_next;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !st_valid || advance;
  assign fire     = st_valid && advance;

  assign idx = BW'(st_word.req_dom - 8'd1);

  assign event_hit = (st_word.prior_dom == st_word.req_dom) &&
                     (st_word.req_dom != 8'd0) &&
                     (st_word.req_dom <= 8'(BUCKET_CNT)) &&
                     (st_word.req_dom != st_word.holder_dom);

  assign cnt_inc   = counters[idx] + 8'd1;
  assign alert_hit = event_hit && ({1'b0, cnt_inc} >= alert_threshold);
  assign cnt_next  = alert_hit ? '0 : cnt_inc;

  // Every appended entry is at least the maximum of the entries it follows, and
  // a cleared history is all zero, so each history stays in ascending order and
  // the maximum of the surviving entries is simply the newest one.
  assign newest   = hist[idx][HISTORY_DEPTH-1];
  assign appended = (newest == cid_pkg::HIST_MAX) ? newest : newest + 16'd1;

  assign window_inc = {1'b0, window_count} + 17'd1;
  assign win_clear  = window_inc >= {1'b0, interval_length};

  for (genvar k = 0; k < cid_pkg::OUT_HIST; k++) begin : g_sel
    if (k < HISTORY_DEPTH) begin : g_live
      assign sel_hist[k] = alert_hit ? hist[idx][k] : '0;
    end else begin : g_zero
      assign sel_hist[k] = '0;
    end
  end

  always_comb begin
    out_word_next               = '0;
    out_word_next.alert         = alert_hit;
    out_word_next.alert_bucket  = alert_hit ? st_word.req_dom[2:0] : '0;
    out_word_next.event_counted = event_hit;
    out_word_next.history       = sel_hist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alert_threshold <= cid_pkg::ALERT_THRESHOLD_RESET;
      interval_length <= cid_pkg::INTERVAL_LENGTH_RESET;
      window_count    <= '0;
      for (int b = 0; b < BUCKET_CNT; b++) begin
        counters[b] <= '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          hist[b][k] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cid_pkg::REG_ALERT_THRESHOLD: alert_threshold <= cfg_data[cid_pkg::THRESH_W-1:0];
          cid_pkg::REG_INTERVAL_LENGTH: interval_length <= cfg_data[cid_pkg::WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        if (win_clear) begin
          window_count <= '0;
          for (int b = 0; b < BUCKET_CNT; b++) begin
            counters[b] <= '0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
              hist[b][k] <= '0;
            end
          end
        end else begin
          window_count <= window_inc[cid_pkg::WINDOW_W-1:0];
          if (event_hit) begin
            counters[idx] <= cnt_next;
            for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
              hist[idx][k] <= hist[idx][k+1];
            end
            hist[idx][HISTORY_DEPTH-1] <= appended;
          end
        end
      end
    end
  end

  // Input register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        st_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= st_valid;
      end
    end
    if (s_tvalid && s_tready) begin
      st_word <= cid_pkg::in_word_t'(s_tdata[cid_pkg::IN_FIELDS_W-1:0]);
    end
    if (fire) begin
      out_word <= out_word_next;
    end
  end

  assign m_tdata = out_word;

  `CID_ASSERT_SAME(a_alert_needs_event, m_tvalid && out_word.alert,
    out_word.event_counted, "alert without a counted event")
  `CID_ASSERT_SAME(a_quiet_history_zero, m_tvalid && !out_word.alert,
    out_word.history == '0 && out_word.alert_bucket == '0, "history reported without alert")
  `CID_ASSERT_NEXT(a_window_cleared, fire && win_clear,
    window_count == '0, "window count not cleared")
  `CID_ASSERT_NEXT(a_stalled_word_held, st_valid && !advance,
    st_valid && $stable(st_word), "pending word lost under stall")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int BUCKET_CNT    = 4;
  localparam int HISTORY_DEPTH = 8;
  localparam int DRAIN_CYCLES  = 6;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_LEN      = 300;
  localparam int STALL_LIMIT   = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  cid_pkg::in_word_t  s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  cid_pkg::out_word_t m_tdata;
  logic                            cfg_we = 1'b0;
  logic [cid_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cid_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  always #4 clk = ~clk;

  cyclic_interference_detector #(
    .BUCKET_CNT   (BUCKET_CNT),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Detector state as the testbench expects it to be.
  logic [cid_pkg::THRESH_W-1:0] threshold_cfg = cid_pkg::ALERT_THRESHOLD_RESET;
  logic [cid_pkg::WINDOW_W-1:0] interval_cfg  = cid_pkg::INTERVAL_LENGTH_RESET;
  logic [cid_pkg::COUNT_W-1:0]  event_count [BUCKET_CNT] = '{default: '0};
  logic [cid_pkg::HIST_W-1:0]   bucket_hist [BUCKET_CNT][HISTORY_DEPTH] =
      '{default: '{default: '0}};
  logic [cid_pkg::WINDOW_W-1:0] window_pos = '0;

  cid_pkg::in_word_t  access_q[$];
  cid_pkg::out_word_t expected_q[$];
  int                 fail_count = 0;
  int                 src_idle_pct = 0;
  int                 sink_idle_pct = 0;

  function automatic cid_pkg::out_word_t predict_access(cid_pkg::in_word_t a);
    cid_pkg::out_word_t          r;
    int                          b;
    logic [cid_pkg::COUNT_W-1:0] cnt;
    logic [16:0]                 mx;
    logic [16:0]                 next_pos;
    r = '0;
    if (a.prior_dom == a.req_dom && a.req_dom >= 1 &&
        a.req_dom <= BUCKET_CNT && a.req_dom != a.holder_dom) begin
      b = int'(a.req_dom) - 1;
      cnt = event_count[b] + 8'd1;
      r.event_counted = 1'b1;
      if ({1'b0, cnt} >= threshold_cfg) begin
        r.alert = 1'b1;
        r.alert_bucket = a.req_dom[cid_pkg::BUCKET_ID_W-1:0];
        for (int k = 0; k < cid_pkg::OUT_HIST && k < HISTORY_DEPTH; k++)
          r.history[k] = bucket_hist[b][k];
        cnt = '0;
      end
      event_count[b] = cnt;
      // Drop the oldest entry and append one past the largest survivor.
      mx = '0;
      for (int k = 1; k < HISTORY_DEPTH; k++) begin
        if (bucket_hist[b][k] > mx) mx = {1'b0, bucket_hist[b][k]};
        bucket_hist[b][k-1] = bucket_hist[b][k];
      end
      mx = mx + 17'd1;
      bucket_hist[b][HISTORY_DEPTH-1] =
          (mx > {1'b0, cid_pkg::HIST_MAX}) ? cid_pkg::HIST_MAX : mx[cid_pkg::HIST_W-1:0];
    end
    next_pos = {1'b0, window_pos} + 17'd1;
    if (next_pos >= {1'b0, interval_cfg}) begin
      window_pos = '0;
      for (int i = 0; i < BUCKET_CNT; i++) begin
        event_count[i] = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) bucket_hist[i][k] = '0;
      end
    end else begin
      window_pos = next_pos[cid_pkg::WINDOW_W-1:0];
    end
    return r;
  endfunction

  function automatic cid_pkg::in_word_t access(logic [7:0] prev, logic [7:0] req,
                                               logic [7:0] cur);
    cid_pkg::in_word_t w;
    w.prior_dom  = prev;
    w.req_dom    = req;
    w.holder_dom = cur;
    return w;
  endfunction

  function automatic cid_pkg::in_word_t make_event(logic [7:0] d);
    logic [7:0] cur;
    do cur = 8'($urandom); while (cur == d);
    return access(d, d, cur);
  endfunction

  // Mostly counted events, with near misses and plain noise mixed in.
  function automatic cid_pkg::in_word_t make_random_access(int focus_pct);
    cid_pkg::in_word_t w;
    int                sel;
    logic [7:0]        d;
    logic [7:0]        other;
    sel = $urandom_range(99);
    d = ($urandom_range(99) < focus_pct) ? 8'd1 : 8'($urandom_range(BUCKET_CNT, 1));
    if (sel < 72) begin
      w = make_event(d);
    end else if (sel < 79) begin
      w = access(d, d, d);
    end else if (sel < 85) begin
      other = 8'($urandom_range(255, BUCKET_CNT + 1));
      w = access(other, other, 8'($urandom));
    end else if (sel < 89) begin
      w = access(8'd0, 8'd0, 8'($urandom));
    end else if (sel < 93) begin
      do other = 8'($urandom_range(BUCKET_CNT, 0)); while (other == d);
      w = access(other, d, 8'($urandom));
    end else begin
      w = cid_pkg::in_word_t'(24'($urandom));
    end
    return w;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(cid_pkg::out_word_t got);
    cid_pkg::out_word_t want;
    if (expected_q.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("alert", 32'(want.alert), 32'(got.alert));
    compare_field("alert_bucket", 32'(want.alert_bucket), 32'(got.alert_bucket));
    compare_field("event_counted", 32'(want.event_counted), 32'(got.event_counted));
    for (int k = 0; k < cid_pkg::OUT_HIST; k++)
      compare_field($sformatf("history_%0d", k), 32'(want.history[k]), 32'(got.history[k]));
    compare_field("pad", 32'(want.pad), 32'(got.pad));
  endfunction

  // Sender: keeps tdata steady until the word is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_q = {expected_q, predict_access(s_tdata)};
      if (!s_tvalid || s_tready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tdata  <= access_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver, with one long hold-off so that the detector backs up.
  int  results_seen = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
        results_seen <= results_seen + 1;
      end
      if (!held_once && results_seen == HOLD_AT) begin
        held_once <= 1'b1;
        hold_left <= HOLD_LEN;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[cyclic_interference_detector] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(logic [cid_pkg::CFG_INDEX_W-1:0] idx,
                           logic [cid_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      cid_pkg::REG_ALERT_THRESHOLD: threshold_cfg = val[cid_pkg::THRESH_W-1:0];
      cid_pkg::REG_INTERVAL_LENGTH: interval_cfg = val[cid_pkg::WINDOW_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (access_q.size() != 0 || s_tvalid || expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [cid_pkg::CFG_DATA_W-1:0] thr,
                              logic [cid_pkg::CFG_DATA_W-1:0] intv);
    wait_idle();
    write_reg(cid_pkg::REG_ALERT_THRESHOLD, thr);
    write_reg(cid_pkg::REG_INTERVAL_LENGTH, intv);
  endtask

  task automatic run_phase(logic [cid_pkg::CFG_DATA_W-1:0] thr,
                           logic [cid_pkg::CFG_DATA_W-1:0] intv, int items, int src_pct,
                           int sink_pct, int focus_pct);
    program_regs(thr, intv);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (items) access_q = {access_q, make_random_access(focus_pct)};
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: threshold 3, window of 10 words.
    src_idle_pct  = 14;
    sink_idle_pct = 63;
    access_q = {access_q, access(8'd0, 8'd0, 8'd0)};
    access_q = {access_q, access(8'd255, 8'd255, 8'd255)};
    access_q = {access_q, access(8'd5, 8'd5, 8'd0)};
    access_q = {access_q, access(8'd1, 8'd1, 8'd1)};
    access_q = {access_q, access(8'd1, 8'd2, 8'd0)};
    access_q = {access_q, access(8'd1, 8'd1, 8'd0)};
    access_q = {access_q, access(8'd1, 8'd1, 8'd255)};
    access_q = {access_q, access(8'd1, 8'd1, 8'd2)};
    access_q = {access_q, access(8'd4, 8'd4, 8'd3)};
    access_q = {access_q, access(8'd4, 8'd4, 8'd128)};
    repeat (3) access_q = {access_q, access(8'd4, 8'd4, 8'd0)};

    // Threshold zero alerts on every event.
    program_regs(16'd0, 16'd65535);
    access_q = {access_q, access(8'd2, 8'd2, 8'd0)};
    access_q = {access_q, access(8'd2, 8'd2, 8'd1)};
    access_q = {access_q, access(8'd3, 8'd3, 8'd170)};

    // Zero-length window below the current count: clears after every word.
    program_regs(16'd511, 16'd0);
    access_q = {access_q, access(8'd3, 8'd3, 8'd0)};
    access_q = {access_q, access(8'd3, 8'd3, 8'd85)};

    run_phase(16'd3, 16'd40, 150, 14, 63, 30);
    run_phase(16'd0, 16'd65535, 100, 14, 63, 30);
    // Long window and unreachable threshold, so the bucket counters count up without alerting.
    run_phase(16'd256, 16'd65535, 300, 63, 14, 90);
    run_phase(16'd5, 16'd100, 100, 63, 14, 30);
    run_phase(16'd255, 16'd1, 100, 0, 0, 30);
    run_phase(16'd2, 16'd20, 200, 0, 0, 30);

    wait_idle();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("[cyclic_interference_detector] OK");
    end else begin
      $display("[cyclic_interference_detector] ERROR");
    end
    $finish;
  end

endmodule
